>>> rtl/slm_pkg.sv
// Shared types, constants and elaboration-time functions for the stereo LED peak meter.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
`default_nettype none

package slm_pkg;

  localparam int unsigned LEVEL_W = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned LIT_W   = 5;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned THR_W   = LEVEL_W + 1;   // one spare bit: "never lit" threshold
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_STEP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TIME_MS = 2'd2;

  localparam logic [CFG_DATA_W-1:0] DECAY_FACTOR_RST = 16'd57672;
  localparam logic [CFG_DATA_W-1:0] RELEASE_STEP_RST = 16'd655;
  localparam logic [CFG_DATA_W-1:0] HOLD_TIME_MS_RST = 16'd1000;

  localparam int unsigned FULL_SCALE = 65535;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] decay_factor;
    logic [CFG_DATA_W-1:0] release_step;
    logic [CFG_DATA_W-1:0] hold_time_ms;
  } cfg_t;

  typedef struct packed {
    logic [LIT_W-1:0] lit;
    logic [IDX_W-1:0] hold_index;
    logic             hold_shown;
  } lane_res_t;

  // log2(x) in Q8.24 by repeated squaring of a Q30 mantissa, truncating each step
  function automatic longint lg_q24(input int unsigned x);
    int unsigned n;
    logic [63:0] y;
    logic [31:0] frac;
    n = 0;
    frac = '0;
    if (x == 0) begin
      return 0;
    end
    for (int b = 0; b < 32; b++) begin
      if ((x >> b) > 1) begin
        n = b + 1;
      end
    end
    y = (64'(x) << 30) >> n;
    for (int i = 0; i < 24; i++) begin
      y = (y * y) >> 30;
      frac = frac << 1;
      if (y >= 64'h8000_0000) begin
        y = y >> 1;
        frac[0] = 1'b1;
      end
    end
    return longint'(n) * 64'sd16777216 + longint'(frac);
  endfunction

  function automatic bit seg_hit(input int unsigned x, input int k, input int s);
    longint d;
    longint m;
    d = lg_q24(x) - lg_q24(FULL_SCALE);
    m = longint'(2 * k - 1 - 2 * s);
    return (longint'(5 * s) * d) >= (64'sd6 * m * lg_q24(10));
  endfunction

  function automatic bit floor_hit(input int unsigned x);
    longint d;
    d = lg_q24(x) - lg_q24(FULL_SCALE);
    return (64'sd125 * d) > (-64'sd294 * lg_q24(10));
  endfunction

  // smallest nonzero level that lights segment k; 65536 when none does
  function automatic logic [THR_W-1:0] seg_thr(input int k, input int s);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 1;
    hi = FULL_SCALE + 1;
    for (int i = 0; i < 18; i++) begin
      if (lo < hi) begin
        mid = (lo + hi) / 2;
        if (seg_hit(mid, k, s)) begin
          hi = mid;
        end else begin
          lo = mid + 1;
        end
      end
    end
    return THR_W'(hi);
  endfunction

  // smallest nonzero level above the hold-marker floor
  function automatic logic [THR_W-1:0] floor_thr();
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 1;
    hi = FULL_SCALE + 1;
    for (int i = 0; i < 18; i++) begin
      if (lo < hi) begin
        mid = (lo + hi) / 2;
        if (floor_hit(mid)) begin
          hi = mid;
        end else begin
          lo = mid + 1;
        end
      end
    end
    return THR_W'(hi);
  endfunction

endpackage

`default_nettype wire

>>> rtl/slm_in_if.sv
// Input channel of the peak meter: valid/ready plus left, right level and timestamp.
// Depends on slm_pkg for field widths.
`default_nettype none

interface slm_in_if;
  logic                          valid;
  logic                          ready;
  logic [slm_pkg::LEVEL_W-1:0]   left_level;
  logic [slm_pkg::LEVEL_W-1:0]   right_level;
  logic [slm_pkg::TIME_W-1:0]    now_ms;

  modport source (output valid, left_level, right_level, now_ms, input ready);
  modport sink   (input valid, left_level, right_level, now_ms, output ready);
endinterface

`default_nettype wire

>>> rtl/slm_out_if.sv
// Result channel of the peak meter: valid/ready plus per-channel segment fields.
// Depends on slm_pkg for field widths.
`default_nettype none

interface slm_out_if;
  logic                        valid;
  logic                        ready;
  logic [slm_pkg::LIT_W-1:0]   left_lit;
  logic [slm_pkg::IDX_W-1:0]   left_hold_index;
  logic                        left_hold_shown;
  logic [slm_pkg::LIT_W-1:0]   right_lit;
  logic [slm_pkg::IDX_W-1:0]   right_hold_index;
  logic                        right_hold_shown;

  modport source (output valid, left_lit, left_hold_index, left_hold_shown,
                  right_lit, right_hold_index, right_hold_shown, input ready);
  modport sink   (input valid, left_lit, left_hold_index, left_hold_shown,
                  right_lit, right_hold_index, right_hold_shown, output ready);
endinterface

`default_nettype wire

>>> rtl/slm_lane.sv
// One meter channel: decaying peak, held level with hold timer, and segment mapping.
// Depends on slm_pkg (cfg_t, lane_res_t, threshold functions).
`default_nettype none

module slm_lane #(
  parameter int SEGMENT_COUNT = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire slm_pkg::cfg_t                 cfg,
  input  wire logic [slm_pkg::LEVEL_W-1:0]   level,
  input  wire logic [slm_pkg::TIME_W-1:0]    now_ms,
  output slm_pkg::lane_res_t                 res
);

  localparam int CNT_W = $clog2(SEGMENT_COUNT + 1);
  localparam logic [slm_pkg::THR_W-1:0] FLOOR_THR = slm_pkg::floor_thr();

  logic [slm_pkg::LEVEL_W-1:0] peak_r, peak_nxt;
  logic [slm_pkg::LEVEL_W-1:0] held_r, held_nxt;
  logic [slm_pkg::TIME_W-1:0]  since_r, since_nxt;

  logic [2*slm_pkg::LEVEL_W-1:0] prod;
  logic [slm_pkg::LEVEL_W-1:0]   dec;
  logic [slm_pkg::LEVEL_W-1:0]   rel;
  logic [slm_pkg::TIME_W-1:0]    age;

  logic [SEGMENT_COUNT-1:0] peak_hit;
  logic [SEGMENT_COUNT-1:0] held_hit;
  logic [CNT_W-1:0]         lit_cnt;
  logic [CNT_W-1:0]         hold_cnt;
  logic [CNT_W-1:0]         idx;

  // state update
  always_comb begin
    prod = 32'(peak_r) * 32'(cfg.decay_factor);
    dec  = prod[2*slm_pkg::LEVEL_W-1:slm_pkg::LEVEL_W];
    peak_nxt = (dec > level) ? dec : level;

    age = now_ms - since_r;
    rel = (held_r > cfg.release_step) ? (held_r - cfg.release_step) : '0;
    held_nxt  = held_r;
    since_nxt = since_r;
    if (level > held_r) begin
      held_nxt  = level;
      since_nxt = now_ms;
    end else if (age > 32'(cfg.hold_time_ms)) begin
      held_nxt = (rel > level) ? rel : level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r  <= '0;
      held_r  <= '0;
      since_r <= '0;
    end else if (en) begin
      peak_r  <= peak_nxt;
      held_r  <= held_nxt;
      since_r <= since_nxt;
    end
  end

  // threshold bank per segment, thresholds fixed at elaboration
  for (genvar k = 0; k < SEGMENT_COUNT; k++) begin : g_seg
    localparam logic [slm_pkg::THR_W-1:0] THR = slm_pkg::seg_thr(k + 1, SEGMENT_COUNT);
    assign peak_hit[k] = {1'b0, peak_nxt} >= THR;
    assign held_hit[k] = {1'b0, held_nxt} >= THR;
  end

  always_comb begin
    lit_cnt  = '0;
    hold_cnt = '0;
    for (int k = 0; k < SEGMENT_COUNT; k++) begin
      lit_cnt  = lit_cnt  + CNT_W'(peak_hit[k]);
      hold_cnt = hold_cnt + CNT_W'(held_hit[k]);
    end
    idx = (hold_cnt != '0) ? (hold_cnt - CNT_W'(1)) : '0;

    res.lit = (32'(lit_cnt) > 32'd31) ? 5'd31 : slm_pkg::LIT_W'(lit_cnt);
    res.hold_index = (32'(idx) > 32'd15) ? 4'd15 : slm_pkg::IDX_W'(idx);
    res.hold_shown = (held_nxt != '0) && ({1'b0, held_nxt} >= FLOOR_THR) &&
                     (idx >= lit_cnt);
  end

endmodule

`default_nettype wire

>>> rtl/stereo_led_peak_meter_top.sv
// Top level of the stereo LED peak meter: config registers, two channel lanes, result register.
// Depends on slm_pkg, slm_in_if, slm_out_if and slm_lane.
`default_nettype none

// Stereo LED peak meter. Each input transfer carries a left and a right magnitude
// (unsigned Q0.16) and a millisecond timestamp; each one yields exactly one result
// transfer with, per channel, the lit segment count of the decaying peak, the segment
// index of the hold marker and a flag telling whether the marker shows above the bar.
// Throughput is one item per clock: both channel lanes update their peak and held
// level and map them to segments in the cycle of the input transfer, and the result
// sits in a single output register, so a new item is taken whenever that register is
// empty or is being emptied in the same cycle. The result is valid in the cycle after
// the input transfer. The critical path is one 16x16 multiply for the peak
// decay followed by a bank of parallel threshold compares and a segment count.
// Configuration (decay_factor, release_step, hold_time_ms at indexes 0..2) is written
// through cfg_we/cfg_index/cfg_wdata and should only change while the meter is idle.
// SEGMENT_COUNT sets the length of the bar (4..16); the segment thresholds of the
// -48..0 dB map are computed at elaboration.
module stereo_led_peak_meter_top #(
  parameter int SEGMENT_COUNT = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  slm_in_if.sink                                  in_ch,
  slm_out_if.source                               out_ch,
  input  wire logic                               cfg_we,
  input  wire logic [slm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [slm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  slm_pkg::cfg_t       cfg_r;
  slm_pkg::lane_res_t  left_res, right_res;
  slm_pkg::lane_res_t  left_res_r, right_res_r;
  logic                out_valid_r;
  logic                in_ready;
  logic                in_xfer;

  // take a new item while the result register is free or draining this cycle
  assign in_ready     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = in_ready;
  assign in_xfer      = in_ch.valid && in_ready;

  // configuration registers; writes beyond the register list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.decay_factor <= slm_pkg::DECAY_FACTOR_RST;
      cfg_r.release_step <= slm_pkg::RELEASE_STEP_RST;
      cfg_r.hold_time_ms <= slm_pkg::HOLD_TIME_MS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        slm_pkg::REG_DECAY_FACTOR: cfg_r.decay_factor <= cfg_wdata;
        slm_pkg::REG_RELEASE_STEP: cfg_r.release_step <= cfg_wdata;
        slm_pkg::REG_HOLD_TIME_MS: cfg_r.hold_time_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // two identical lanes, one per channel, advance together on each input transfer
  slm_lane #(.SEGMENT_COUNT(SEGMENT_COUNT)) u_lane_left (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (in_xfer),
    .cfg    (cfg_r),
    .level  (in_ch.left_level),
    .now_ms (in_ch.now_ms),
    .res    (left_res)
  );

  slm_lane #(.SEGMENT_COUNT(SEGMENT_COUNT)) u_lane_right (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (in_xfer),
    .cfg    (cfg_r),
    .level  (in_ch.right_level),
    .now_ms (in_ch.now_ms),
    .res    (right_res)
  );

  // merge both lanes into one result word; hold it until the transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      left_res_r  <= left_res;
      right_res_r <= right_res;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.left_lit         = left_res_r.lit;
  assign out_ch.left_hold_index  = left_res_r.hold_index;
  assign out_ch.left_hold_shown  = left_res_r.hold_shown;
  assign out_ch.right_lit        = right_res_r.lit;
  assign out_ch.right_hold_index = right_res_r.hold_index;
  assign out_ch.right_hold_shown = right_res_r.hold_shown;

endmodule

`default_nettype wire

>>> verif/stereo_led_peak_meter_top_tb.sv
// Self-checking testbench for stereo_led_peak_meter_top: directed and random level transfers
// checked against an in-bench model of the peak, hold and segment mapping.
// Depends on rtl/slm_pkg.sv, rtl/slm_in_if.sv, rtl/slm_out_if.sv and the RTL of the meter.
`timescale 1ns / 100ps

module stereo_led_peak_meter_top_tb;

  localparam int SEGMENTS     = 16;
  localparam int PHASE_ITEMS  = 105;
  localparam int CHOKE_CYCLES = 200;
  localparam int DRAIN_CYCLES = 4;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [slm_pkg::LEVEL_W-1:0] left_level;
    logic [slm_pkg::LEVEL_W-1:0] right_level;
    logic [slm_pkg::TIME_W-1:0]  now_ms;
  } level_sample_t;

  typedef struct packed {
    slm_pkg::lane_res_t left;
    slm_pkg::lane_res_t right;
  } meter_reading_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [slm_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [slm_pkg::CFG_DATA_W-1:0] cfg_wdata;

  slm_in_if  in_ch ();
  slm_out_if out_ch ();

  stereo_led_peak_meter_top #(
    .SEGMENT_COUNT (SEGMENTS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Meter model: register copy, per-channel peak/held state, log constants
  // ---------------------------------------------------------------------------
  slm_pkg::cfg_t               meter_cfg;
  logic [slm_pkg::LEVEL_W-1:0] peak_lv [2];
  logic [slm_pkg::LEVEL_W-1:0] held_lv [2];
  logic [slm_pkg::TIME_W-1:0]  held_at [2];
  longint                      lg_full_scale;
  longint                      lg_ten;

  level_sample_t  level_queue [$];   // samples waiting for the driver
  meter_reading_t readings_due [$];  // predicted readings, oldest first

  // Handshake bookkeeping shared between the processes
  logic in_xfer  = 1'b0;
  logic out_xfer = 1'b0;
  bit   offering = 1'b0;
  int   tx_idle_max = 0;
  int   rx_idle_max = 0;
  int   choke_tickets = 0;

  int   fault_count = 0;
  int   samples_sent = 0;
  int   readings_seen = 0;
  int   phases_run = 0;
  int   cycle_count = 0;
  logic [slm_pkg::LEVEL_W-1:0] last_lvl [2];
  logic [slm_pkg::TIME_W-1:0]  ms_clock;

  // log2 of a nonzero level in Q8.24: integer part from the leading one, then
  // 24 fraction bits by squaring a Q30 mantissa and truncating each time
  function automatic longint log2_q24(input int unsigned x);
    int unsigned msb;
    logic [63:0] mant;
    logic [23:0] frac;
    msb  = 0;
    frac = '0;
    for (int b = 31; b > 0; b--) begin
      if (msb == 0 && x[b]) begin
        msb = b;
      end
    end
    mant = (64'(x) << 30) >> msb;
    for (int i = 0; i < 24; i++) begin
      mant = (mant * mant) >> 30;
      frac = {frac[22:0], mant[31]};
      if (mant[31]) begin
        mant = mant >> 1;
      end
    end
    return (longint'(msb) << 24) + longint'({40'd0, frac});
  endfunction

  // Segments lit on the -48..0 dB map, rounded to the nearest segment
  function automatic int unsigned segments_lit(input logic [slm_pkg::LEVEL_W-1:0] lvl);
    longint rel;
    int unsigned cnt;
    cnt = 0;
    if (lvl == '0) begin
      return 0;
    end
    rel = log2_q24(lvl) - lg_full_scale;
    for (int k = 1; k <= SEGMENTS; k++) begin
      if (longint'(5 * SEGMENTS) * rel >= longint'(6 * (2 * k - 1 - 2 * SEGMENTS)) * lg_ten) begin
        cnt++;
      end
    end
    return cnt;
  endfunction

  // Held level above roughly -47 dB
  function automatic bit above_marker_floor(input logic [slm_pkg::LEVEL_W-1:0] lvl);
    if (lvl == '0) begin
      return 1'b0;
    end
    return 64'sd125 * (log2_q24(lvl) - lg_full_scale) > -64'sd294 * lg_ten;
  endfunction

  // Advance one channel by a sample and return its display fields
  function automatic slm_pkg::lane_res_t step_lane(input int ch,
                                                   input logic [slm_pkg::LEVEL_W-1:0] lvl,
                                                   input logic [slm_pkg::TIME_W-1:0] now);
    logic [31:0]                 scaled;
    logic [slm_pkg::TIME_W-1:0]  age;
    logic [slm_pkg::LEVEL_W-1:0] dropped;
    int unsigned                 lit;
    int unsigned                 hold_cnt;
    int unsigned                 idx;
    slm_pkg::lane_res_t          res;
    scaled = (32'(peak_lv[ch]) * 32'(meter_cfg.decay_factor)) >> 16;
    peak_lv[ch] = (scaled > 32'(lvl)) ? scaled[slm_pkg::LEVEL_W-1:0] : lvl;
    if (lvl > held_lv[ch]) begin
      held_lv[ch] = lvl;
      held_at[ch] = now;
    end else begin
      age = now - held_at[ch];
      if (age > 32'(meter_cfg.hold_time_ms)) begin
        dropped = (held_lv[ch] > meter_cfg.release_step) ?
                  held_lv[ch] - meter_cfg.release_step : '0;
        held_lv[ch] = (dropped > lvl) ? dropped : lvl;
      end
    end
    lit      = segments_lit(peak_lv[ch]);
    hold_cnt = segments_lit(held_lv[ch]);
    idx      = (hold_cnt > 0) ? hold_cnt - 1 : 0;
    res.hold_shown = above_marker_floor(held_lv[ch]) && (idx >= lit);
    res.lit        = (lit > 31) ? 5'd31 : 5'(lit);
    res.hold_index = (idx > 15) ? 4'd15 : 4'(idx);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Edge sampler: check readings, then predict for a new level transfer.
  // Compare before predicting - the result is registered, so a reading can never
  // belong to the sample taken at the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : sample_edges
    meter_reading_t got;
    meter_reading_t want;
    level_sample_t  smp;
    in_xfer  <= rst_n && in_ch.valid && in_ch.ready;
    out_xfer <= rst_n && out_ch.valid && out_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      readings_seen++;
      got.left.lit         = out_ch.left_lit;
      got.left.hold_index  = out_ch.left_hold_index;
      got.left.hold_shown  = out_ch.left_hold_shown;
      got.right.lit        = out_ch.right_lit;
      got.right.hold_index = out_ch.right_hold_index;
      got.right.hold_shown = out_ch.right_hold_shown;
      if (readings_due.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("[%0t] reading %0d arrived with none outstanding", $realtime, readings_seen);
        end
      end else begin
        want = readings_due.pop_front();
        if (got !== want) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("[%0t] reading %0d mismatch (exp/got): L lit %0d/%0d idx %0d/%0d shown %0d/%0d",
                     $realtime, readings_seen, want.left.lit, got.left.lit,
                     want.left.hold_index, got.left.hold_index,
                     want.left.hold_shown, got.left.hold_shown);
            $display("    R lit %0d/%0d idx %0d/%0d shown %0d/%0d",
                     want.right.lit, got.right.lit, want.right.hold_index,
                     got.right.hold_index, want.right.hold_shown, got.right.hold_shown);
          end
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      samples_sent++;
      smp.left_level  = in_ch.left_level;
      smp.right_level = in_ch.right_level;
      smp.now_ms      = in_ch.now_ms;
      want.left  = step_lane(0, smp.left_level, smp.now_ms);
      want.right = step_lane(1, smp.right_level, smp.now_ms);
      readings_due.push_back(want);
    end
  end

  // ---------------------------------------------------------------------------
  // Level driver: wait a drawn gap before each sample, then hold it until the
  // transfer. valid gets exactly one nonblocking write per falling edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_levels
    level_sample_t nxt;
    int            gap_left;
    bit            gap_drawn;
    if (!rst_n) begin
      offering  = 1'b0;
      gap_drawn = 1'b0;
      in_ch.valid <= 1'b0;
    end else begin
      if (in_xfer) begin
        offering = 1'b0;
      end
      if (!offering && level_queue.size() > 0) begin
        if (!gap_drawn) begin
          gap_left  = $urandom_range(0, tx_idle_max);
          gap_drawn = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          nxt = level_queue.pop_front();
          in_ch.left_level  <= nxt.left_level;
          in_ch.right_level <= nxt.right_level;
          in_ch.now_ms      <= nxt.now_ms;
          offering  = 1'b1;
          gap_drawn = 1'b0;
        end
      end
      in_ch.valid <= offering;
    end
  end

  // ---------------------------------------------------------------------------
  // Reading sink: draw a stall after every transfer; a choke request overrides
  // it with a long hold-off so the output register fills and input backs up.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_ready
    int rx_stall;
    int choke_served;
    if (!rst_n) begin
      rx_stall     = 0;
      choke_served = 0;
      out_ch.ready <= 1'b0;
    end else begin
      if (out_xfer) begin
        rx_stall = $urandom_range(0, rx_idle_max);
      end
      if (choke_served != choke_tickets) begin
        choke_served = choke_tickets;
        rx_stall     = CHOKE_CYCLES;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: give up well beyond the slowest legal run
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d readings outstanding",
               cycle_count, readings_due.size());
      $display("** stereo_led_peak_meter_top: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_sample(input logic [slm_pkg::LEVEL_W-1:0] lft,
                              input logic [slm_pkg::LEVEL_W-1:0] rgt,
                              input logic [slm_pkg::TIME_W-1:0] now);
    level_sample_t s;
    s.left_level  = lft;
    s.right_level = rgt;
    s.now_ms      = now;
    level_queue.push_back(s);
  endtask

  // Write one register on the next falling edge and mirror it in the model;
  // the caller drops cfg_we once the burst of writes is done
  task automatic write_reg(input logic [slm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [slm_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      slm_pkg::REG_DECAY_FACTOR: meter_cfg.decay_factor = val;
      slm_pkg::REG_RELEASE_STEP: meter_cfg.release_step = val;
      slm_pkg::REG_HOLD_TIME_MS: meter_cfg.hold_time_ms = val;
      default: ;
    endcase
  endtask

  // Hold until every sample is sent and every reading is back, then let the
  // pipeline settle
  task automatic wait_drained();
    do begin
      @(posedge clk);
    end while (level_queue.size() != 0 || offering || readings_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Mix of silence, full-range, near-floor, near-full-scale, power-of-two, low and repeated levels
  function automatic logic [slm_pkg::LEVEL_W-1:0] pick_level(input int ch);
    logic [slm_pkg::LEVEL_W-1:0] lvl;
    case ($urandom_range(0, 7))
      0:       lvl = '0;
      1, 2:    lvl = slm_pkg::LEVEL_W'($urandom_range(0, 65535));
      3:       lvl = slm_pkg::LEVEL_W'($urandom_range(0, 400));
      4:       lvl = slm_pkg::LEVEL_W'(65535 - $urandom_range(0, 3000));
      5:       lvl = slm_pkg::LEVEL_W'((1 << $urandom_range(0, 15)) + $urandom_range(0, 2) - 1);
      6:       lvl = last_lvl[ch];
      default: lvl = slm_pkg::LEVEL_W'($urandom_range(0, 8000));
    endcase
    last_lvl[ch] = lvl;
    return lvl;
  endfunction

  // One register setting followed by a block of random samples. Small time steps are
  // the most common draw so peaks decay and holds expire in order, with steps around the
  // hold time, jumps across the 2^32 wrap and random timestamps as noise.
  task automatic run_phase(input logic [slm_pkg::CFG_DATA_W-1:0] decay,
                           input logic [slm_pkg::CFG_DATA_W-1:0] step,
                           input logic [slm_pkg::CFG_DATA_W-1:0] hold_ms, input int tx_max,
                           input int rx_max, input bit choke);
    logic [slm_pkg::LEVEL_W-1:0] lft;
    logic [slm_pkg::LEVEL_W-1:0] rgt;
    write_reg(slm_pkg::REG_DECAY_FACTOR, decay);
    write_reg(slm_pkg::REG_RELEASE_STEP, step);
    write_reg(slm_pkg::REG_HOLD_TIME_MS, hold_ms);
    @(negedge clk);
    cfg_we <= 1'b0;
    tx_idle_max = tx_max;
    rx_idle_max = rx_max;
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: ms_clock += $urandom_range(0, 20);
        4, 5:       ms_clock += 32'(hold_ms) + $urandom_range(0, 2);
        6:          ms_clock += $urandom_range(0, 2 * int'(hold_ms) + 10);
        7:          ms_clock = 32'hFFFF_FFFF - $urandom_range(0, 60);
        default:    ms_clock = $urandom();
      endcase
      lft = pick_level(0);
      rgt = pick_level(1);
      queue_sample(lft, rgt, ms_clock);
    end
    // Choke the reading side while the driver keeps offering back to back
    if (choke) begin
      choke_tickets++;
    end
    wait_drained();
    phases_run++;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.left_level  = '0;
    in_ch.right_level = '0;
    in_ch.now_ms      = '0;
    out_ch.ready      = 1'b0;

    lg_full_scale = log2_q24(slm_pkg::FULL_SCALE);
    lg_ten        = log2_q24(10);
    meter_cfg.decay_factor = slm_pkg::DECAY_FACTOR_RST;
    meter_cfg.release_step = slm_pkg::RELEASE_STEP_RST;
    meter_cfg.hold_time_ms = slm_pkg::HOLD_TIME_MS_RST;
    for (int c = 0; c < 2; c++) begin
      peak_lv[c]  = '0;
      held_lv[c]  = '0;
      held_at[c]  = '0;
      last_lvl[c] = '0;
    end
    ms_clock = '0;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Directed block on the reset register values (hold 1000 ms, release 655)
    tx_idle_max = 3;
    rx_idle_max = 3;
    queue_sample(16'd0,      16'd0,      32'd0);            // silence
    queue_sample(16'hFFFF,   16'd1,      32'd10);           // full scale / smallest level
    queue_sample(16'd0,      16'd0,      32'd1010);         // age equals hold: no release
    queue_sample(16'd0,      16'd0,      32'd1011);         // expired: release, right floors at 0
    queue_sample(16'hAAAA,   16'h5555,   32'hFFFF_FF00);    // release stops at held-step
    queue_sample(16'd0,      16'd0,      32'h0000_0100);    // age across the wrap, still held
    queue_sample(16'd0,      16'd0,      32'h0000_02F0);    // age across the wrap, expired
    queue_sample(16'd261,    16'd262,    32'h0000_0300);    // around the -48 dB bottom of the map
    queue_sample(16'd260,    16'd259,    32'h0000_0301);
    queue_sample(16'hFFFF,   16'hFFFF,   32'h0000_0400);
    queue_sample(16'd64950,  16'hFFFF,   32'h0000_0800);    // fall stops at level; level == held
    queue_sample(16'd0,      16'd0,      32'h0000_0801);
    queue_sample(16'd1,      16'd65534,  32'h0000_1000);
    queue_sample(16'h00FF,   16'hFF00,   32'h5555_5555);
    queue_sample(16'h7FFF,   16'h8000,   32'hAAAA_AAAA);
    queue_sample(16'd0,      16'd0,      32'hFFFF_FFFF);
    queue_sample(16'd0,      16'd0,      32'h0000_0000);
    queue_sample(16'd100,    16'd100,    32'h0001_0000);
    queue_sample(16'd50,     16'd0,      32'h0001_03EA);    // step exceeds held: clamp to level
    queue_sample(16'd0,      16'd50,     32'h0001_07D4);
    queue_sample(16'd16384,  16'd4096,   32'h0001_07D5);
    queue_sample(16'd0,      16'd0,      32'h0001_07D6);
    wait_drained();
    phases_run++;

    // Register settings, extremes included; every register written each phase
    run_phase(16'd0,     16'd65535, 16'd0,     10, 10, 1'b0);
    run_phase(16'd65535, 16'd0,     16'd65535, 0,  0,  1'b0);
    run_phase(16'd57672, 16'd655,   16'd1000,  0,  10, 1'b1);
    run_phase(slm_pkg::CFG_DATA_W'($urandom()), slm_pkg::CFG_DATA_W'($urandom_range(0, 4000)),
              slm_pkg::CFG_DATA_W'($urandom_range(0, 3000)), 10, 0, 1'b0);
    run_phase(16'd32768, 16'd2000,  16'd50,    10, 10, 1'b0);
    run_phase(16'd65535, 16'd65535, 16'd65535, 5,  5,  1'b0);
    run_phase(slm_pkg::CFG_DATA_W'($urandom()), slm_pkg::CFG_DATA_W'($urandom()),
              slm_pkg::CFG_DATA_W'($urandom()), 10, 10, 1'b0);
    run_phase(16'd60000, 16'd100,   16'd500,   10, 10, 1'b0);

    $display("Covered %0d level transfers and %0d readings over %0d register settings,",
             samples_sent, readings_seen, phases_run);
    $display("with random gaps, a long reading stall and %0d faults", fault_count);
    if (fault_count == 0 && readings_due.size() == 0) begin
      $display("** stereo_led_peak_meter_top: PASSED **");
    end else begin
      $display("** stereo_led_peak_meter_top: FAILED **");
    end
    $finish;
  end

endmodule
